[rtl/sprp_pkg.sv]
// Shared types, screen constants and register codes for the sprite projection block.
`default_nettype none
package sprp_pkg;

  localparam int SCREEN_W = 1024;
  localparam int SCREEN_H = 768;
  localparam int HALF_W   = SCREEN_W / 2;
  localparam int HALF_H   = SCREEN_H / 2;
  // bits needed for the half screen width multiplier
  localparam int HW_W     = $clog2(HALF_W + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;

  typedef struct packed {
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [11:0] lift_pixels;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic               visible;
    logic signed [31:0] depth;
    logic signed [15:0] center_col;
    logic        [14:0] extent;
    logic signed [15:0] top_row;
    logic signed [15:0] bottom_row;
    logic signed [15:0] left_col;
    logic signed [15:0] right_col;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] plane_x;
    logic signed [31:0] plane_y;
  } cam_t;

  // camera-space numerators and determinant as sign and magnitude
  typedef struct packed {
    logic               det_nz;
    logic        [63:0] d_mag;
    logic               x_neg;
    logic        [63:0] x_mag;
    logic               y_neg;
    logic        [63:0] y_mag;
    logic signed [11:0] lift;
  } xf_t;

  typedef struct packed {
    logic               det_nz;
    logic               visible;
    logic signed [31:0] depth;
    logic signed [31:0] tx;
    logic signed [11:0] lift;
  } qd_t;

  typedef struct packed {
    logic               det_nz;
    logic               visible;
    logic signed [31:0] depth;
    logic signed [15:0] center;
    logic        [14:0] ext;
    logic signed [11:0] lift;
  } sc_t;

endpackage
`default_nettype wire

[rtl/sprp_xform.sv]
// Camera-space transform: offsets, six products and sign-magnitude differences.
`default_nettype none
module sprp_xform (
  input  wire                  clk,
  input  wire                  rst,
  input  wire sprp_pkg::cam_t  cam,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire sprp_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sprp_pkg::xf_t        out_data
);

  logic v0, v1, v2;
  logic en0, en1, en2;

  logic signed [32:0] sx0, sy0;
  logic signed [11:0] lift0, lift1;
  logic signed [63:0] pd_a, pd_b;
  logic signed [64:0] px_a, px_b, py_a, py_b;

  logic [65:0] dd_c, dx_c, dy_c;

  function automatic logic [63:0] mag64(logic [65:0] val);
    logic [65:0] a;
    a = val[65] ? (~val + 66'd1) : val;
    return a[63:0];
  endfunction

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      sx0   <= {in_data.obj_x[31], in_data.obj_x} - {cam.pos_x[31], cam.pos_x};
      sy0   <= {in_data.obj_y[31], in_data.obj_y} - {cam.pos_y[31], cam.pos_y};
      lift0 <= in_data.lift_pixels;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pd_a  <= cam.plane_x * cam.dir_y;
      pd_b  <= cam.dir_x * cam.plane_y;
      px_a  <= cam.dir_y * sx0;
      px_b  <= cam.dir_x * sy0;
      py_a  <= cam.plane_x * sy0;
      py_b  <= cam.plane_y * sx0;
      lift1 <= lift0;
    end
  end

  assign dd_c = {{2{pd_a[63]}}, pd_a} - {{2{pd_b[63]}}, pd_b};
  assign dx_c = {px_a[64], px_a} - {px_b[64], px_b};
  assign dy_c = {py_a[64], py_a} - {py_b[64], py_b};

  always_ff @(posedge clk) begin
    if (en2) begin
      out_data.det_nz <= |dd_c;
      out_data.d_mag  <= mag64(dd_c);
      out_data.x_neg  <= dx_c[65] ^ dd_c[65];
      out_data.x_mag  <= mag64(dx_c);
      out_data.y_neg  <= dy_c[65] ^ dd_c[65];
      out_data.y_mag  <= mag64(dy_c);
      out_data.lift   <= lift1;
    end
  end

endmodule
`default_nettype wire

[rtl/sprp_qdiv.sv]
// Pipelined Q16.16 restoring divider for depth and lateral offset, one bit a stage.
`default_nettype none
module sprp_qdiv (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire sprp_pkg::xf_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sprp_pkg::qd_t        out_data
);

  localparam int NQ = 32;

  logic v  [0:NQ+1];
  logic en [0:NQ+1];

  logic [63:0] rx [0:NQ];
  logic [63:0] ry [0:NQ];
  logic [63:0] dm [0:NQ];
  logic [31:0] lx [0:NQ];
  logic [31:0] ly [0:NQ];
  logic [31:0] qx [0:NQ];
  logic [31:0] qy [0:NQ];
  logic        ox [0:NQ];
  logic        oy [0:NQ];
  logic        nx [0:NQ];
  logic        ny [0:NQ];
  logic        nz [0:NQ];
  logic signed [11:0] lift [0:NQ];

  logic signed [31:0] depth_c, tx_c;

  function automatic logic signed [31:0] q16_fin(logic ovf, logic [31:0] q, logic neg);
    logic [31:0] r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) r = 32'h8000_0000;
      else r = ~q + 32'd1;
    end else begin
      if (ovf || q > 32'h7fff_ffff) r = 32'h7fff_ffff;
      else r = q;
    end
    return r;
  endfunction

  assign en[NQ+1]  = !v[NQ+1] || out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[NQ+1];

  genvar k;
  generate
    for (k = 0; k <= NQ; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
    for (k = 0; k <= NQ + 1; k++) begin : g_v
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  // quotient overflows once the integer part reaches 2^16
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx[0]   <= {16'b0, in_data.x_mag[63:16]};
      ry[0]   <= {16'b0, in_data.y_mag[63:16]};
      lx[0]   <= {in_data.x_mag[15:0], 16'b0};
      ly[0]   <= {in_data.y_mag[15:0], 16'b0};
      ox[0]   <= {16'b0, in_data.x_mag[63:16]} >= in_data.d_mag;
      oy[0]   <= {16'b0, in_data.y_mag[63:16]} >= in_data.d_mag;
      qx[0]   <= '0;
      qy[0]   <= '0;
      dm[0]   <= in_data.d_mag;
      nx[0]   <= in_data.x_neg;
      ny[0]   <= in_data.y_neg;
      nz[0]   <= in_data.det_nz;
      lift[0] <= in_data.lift;
    end
  end

  generate
    for (k = 1; k <= NQ; k++) begin : g_step
      logic [64:0] shx, shy;
      logic        gex, gey;
      assign shx = {rx[k-1], lx[k-1][31]};
      assign shy = {ry[k-1], ly[k-1][31]};
      assign gex = shx >= {1'b0, dm[k-1]};
      assign gey = shy >= {1'b0, dm[k-1]};
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rx[k]   <= gex ? 64'(shx - {1'b0, dm[k-1]}) : shx[63:0];
          ry[k]   <= gey ? 64'(shy - {1'b0, dm[k-1]}) : shy[63:0];
          lx[k]   <= {lx[k-1][30:0], 1'b0};
          ly[k]   <= {ly[k-1][30:0], 1'b0};
          qx[k]   <= {qx[k-1][30:0], gex};
          qy[k]   <= {qy[k-1][30:0], gey};
          ox[k]   <= ox[k-1];
          oy[k]   <= oy[k-1];
          dm[k]   <= dm[k-1];
          nx[k]   <= nx[k-1];
          ny[k]   <= ny[k-1];
          nz[k]   <= nz[k-1];
          lift[k] <= lift[k-1];
        end
      end
    end
  endgenerate

  assign depth_c = q16_fin(oy[NQ], qy[NQ], ny[NQ]);
  assign tx_c    = q16_fin(ox[NQ], qx[NQ], nx[NQ]);

  always_ff @(posedge clk) begin
    if (en[NQ+1]) begin
      out_data.det_nz  <= nz[NQ];
      out_data.visible <= !depth_c[31] && (depth_c != 32'sd0);
      out_data.depth   <= depth_c;
      out_data.tx      <= tx_c;
      out_data.lift    <= lift[NQ];
    end
  end

endmodule
`default_nettype wire

[rtl/sprp_scale.sv]
// Screen column and sprite size: two pipelined integer dividers by the depth.
`default_nettype none
module sprp_scale (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire sprp_pkg::qd_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sprp_pkg::sc_t        out_data
);

  localparam int NC   = 16;
  localparam int CM_W = 33 + sprp_pkg::HW_W;
  localparam logic [31:0] EXT_NUM = 32'(sprp_pkg::SCREEN_H * 65536);
  // stages: two set-up stages, quotient init, NC bit steps, finish
  localparam int NS = NC + 4;

  logic v  [0:NS-1];
  logic en [0:NS-1];

  // set-up stage 0
  logic              sneg0;
  logic [32:0]       smag0;
  logic [30:0]       dv0;
  logic              nz0, vis0;
  logic signed [31:0] dep0;
  logic signed [11:0] lift0;
  // set-up stage 1
  logic              sneg1;
  logic [CM_W-1:0]   cmag1;
  logic [32:0]       ev1;
  logic [30:0]       dv1;
  logic              nz1, vis1;
  logic signed [31:0] dep1;
  logic signed [11:0] lift1;

  logic [30:0] rc [0:NC];
  logic [32:0] re [0:NC];
  logic [15:0] lc [0:NC];
  logic [15:0] le [0:NC];
  logic [15:0] qc [0:NC];
  logic [15:0] qe [0:NC];
  logic        oc [0:NC];
  logic        oe [0:NC];
  logic        sn [0:NC];
  logic [30:0] dv [0:NC];
  logic [32:0] ev [0:NC];
  logic        nz [0:NC];
  logic        vis [0:NC];
  logic signed [31:0] dep [0:NC];
  logic signed [11:0] lift [0:NC];

  logic [32:0] s_c;
  logic signed [15:0] center_c;
  logic [14:0] ext_c;

  assign en[NS-1]  = !v[NS-1] || out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  genvar k;
  generate
    for (k = 0; k < NS - 1; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
    for (k = 0; k < NS; k++) begin : g_v
      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  endgenerate

  assign s_c = {in_data.depth[31], in_data.depth} + {in_data.tx[31], in_data.tx};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sneg0 <= s_c[32];
      smag0 <= s_c[32] ? (~s_c + 33'd1) : s_c;
      dv0   <= in_data.depth[30:0];
      nz0   <= in_data.det_nz;
      vis0  <= in_data.visible;
      dep0  <= in_data.depth;
      lift0 <= in_data.lift;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sneg1 <= sneg0;
      cmag1 <= CM_W'(smag0) * CM_W'(sprp_pkg::HALF_W);
      ev1   <= 33'(dv0) * 33'd3;
      dv1   <= dv0;
      nz1   <= nz0;
      vis1  <= vis0;
      dep1  <= dep0;
      lift1 <= lift0;
    end
  end

  // size = floor(H*2^16 / depth) / 3 = floor(H*2^16 / (3*depth))
  always_ff @(posedge clk) begin
    if (en[2]) begin
      rc[0]   <= 31'(cmag1 >> 16);
      lc[0]   <= cmag1[15:0];
      oc[0]   <= 64'(cmag1) >= {17'b0, dv1, 16'b0};
      re[0]   <= 33'(EXT_NUM >> 16);
      le[0]   <= EXT_NUM[15:0];
      oe[0]   <= {32'b0, EXT_NUM} >= {15'b0, ev1, 16'b0};
      qc[0]   <= '0;
      qe[0]   <= '0;
      sn[0]   <= sneg1;
      dv[0]   <= dv1;
      ev[0]   <= ev1;
      nz[0]   <= nz1;
      vis[0]  <= vis1;
      dep[0]  <= dep1;
      lift[0] <= lift1;
    end
  end

  generate
    for (k = 1; k <= NC; k++) begin : g_step
      logic [31:0] shc;
      logic [33:0] she;
      logic        gec, gee;
      assign shc = {rc[k-1], lc[k-1][15]};
      assign she = {re[k-1], le[k-1][15]};
      assign gec = shc >= {1'b0, dv[k-1]};
      assign gee = she >= {1'b0, ev[k-1]};
      always_ff @(posedge clk) begin
        if (en[k+2]) begin
          rc[k]   <= gec ? 31'(shc - {1'b0, dv[k-1]}) : shc[30:0];
          re[k]   <= gee ? 33'(she - {1'b0, ev[k-1]}) : she[32:0];
          lc[k]   <= {lc[k-1][14:0], 1'b0};
          le[k]   <= {le[k-1][14:0], 1'b0};
          qc[k]   <= {qc[k-1][14:0], gec};
          qe[k]   <= {qe[k-1][14:0], gee};
          oc[k]   <= oc[k-1];
          oe[k]   <= oe[k-1];
          sn[k]   <= sn[k-1];
          dv[k]   <= dv[k-1];
          ev[k]   <= ev[k-1];
          nz[k]   <= nz[k-1];
          vis[k]  <= vis[k-1];
          dep[k]  <= dep[k-1];
          lift[k] <= lift[k-1];
        end
      end
    end
  endgenerate

  always_comb begin
    if (sn[NC]) begin
      if (oc[NC] || qc[NC] > 16'h8000) center_c = 16'sh8000;
      else center_c = $signed(~qc[NC] + 16'd1);
    end else begin
      if (oc[NC] || qc[NC] > 16'h7fff) center_c = 16'sh7fff;
      else center_c = $signed(qc[NC]);
    end
    if (oe[NC] || qe[NC] > 16'h7fff) ext_c = 15'h7fff;
    else ext_c = qe[NC][14:0];
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_data.det_nz  <= nz[NC];
      out_data.visible <= vis[NC];
      out_data.depth   <= dep[NC];
      out_data.center  <= center_c;
      out_data.ext     <= ext_c;
      out_data.lift    <= lift[NC];
    end
  end

endmodule
`default_nettype wire

[rtl/sprp_rect.sv]
// Draw rectangle clamping and the result register.
`default_nettype none
module sprp_rect (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire sprp_pkg::sc_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sprp_pkg::out_item_t  out_data
);

  localparam logic [17:0] HALF_H18 = 18'(sprp_pkg::HALF_H);
  localparam logic [17:0] H18      = 18'(sprp_pkg::SCREEN_H);
  localparam logic [17:0] W18      = 18'(sprp_pkg::SCREEN_W);
  localparam logic signed [17:0] S16_MIN = -18'sd32768;

  logic        en;
  logic [17:0] h18, lift18, c18;
  logic [17:0] top_c, bot_c, left_c, right_c;
  sprp_pkg::out_item_t res_c;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  assign h18    = {4'b0, in_data.ext[14:1]};
  assign lift18 = {{6{in_data.lift[11]}}, in_data.lift};
  assign c18    = {{2{in_data.center[15]}}, in_data.center};
  assign top_c   = HALF_H18 - h18 + lift18;
  assign bot_c   = HALF_H18 + h18 + lift18;
  assign left_c  = c18 - h18;
  assign right_c = c18 + h18;

  always_comb begin
    res_c = '0;
    if (in_data.det_nz) begin
      res_c.valid_res = 1'b1;
      res_c.depth     = in_data.depth;
      if (in_data.visible) begin
        res_c.visible    = 1'b1;
        res_c.center_col = in_data.center;
        res_c.extent     = in_data.ext;
        res_c.top_row    = top_c[17] ? 16'sd0 : $signed(top_c[15:0]);
        res_c.bottom_row = ($signed(bot_c) >= $signed(H18)) ?
                           $signed(16'(sprp_pkg::SCREEN_H - 1)) : $signed(bot_c[15:0]);
        res_c.left_col   = left_c[17] ? 16'sd0 : $signed(left_c[15:0]);
        // a saturated centre far to the right can push the right edge past 16 bits
        if ($signed(right_c) >= $signed(W18)) begin
          res_c.right_col = $signed(16'(sprp_pkg::SCREEN_W - 1));
        end else if ($signed(right_c) < S16_MIN) begin
          res_c.right_col = 16'sh8000;
        end else begin
          res_c.right_col = $signed(right_c[15:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res_c;
    end
  end

endmodule
`default_nettype wire

[rtl/sprite_screen_projection.sv]
// Top level of the billboard sprite projection block.
// One sprite enters per clock unless the output stalls, and passes in turn through
// the camera-space transform, the Q16.16 divider for depth and lateral offset,
// the column and size dividers, and the rectangle and result register. The
// restoring dividers, which resolve one quotient bit per stage, set most of the
// pipeline depth; throughput is one sprite per cycle unless stalled. Every stage
// holds its beat under back-pressure and empty stages fill while downstream
// waits. Camera registers are written through the plain write port and must
// only change while no sprite is in flight.
`default_nettype none
module sprite_screen_projection (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_en,
  input  wire [sprp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]             cfg_data,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire sprp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output sprp_pkg::out_item_t    out_data
);

  sprp_pkg::cam_t cam;
  sprp_pkg::xf_t  xf_data;
  sprp_pkg::qd_t  qd_data;
  sprp_pkg::sc_t  sc_data;
  logic xf_valid, xf_ready, qd_valid, qd_ready, sc_valid, sc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        sprp_pkg::CFG_POS_X:   cam.pos_x   <= cfg_data;
        sprp_pkg::CFG_POS_Y:   cam.pos_y   <= cfg_data;
        sprp_pkg::CFG_DIR_X:   cam.dir_x   <= cfg_data;
        sprp_pkg::CFG_DIR_Y:   cam.dir_y   <= cfg_data;
        sprp_pkg::CFG_PLANE_X: cam.plane_x <= cfg_data;
        sprp_pkg::CFG_PLANE_Y: cam.plane_y <= cfg_data;
        default: ;
      endcase
    end
  end

  sprp_xform u_xform (
    .clk(clk), .rst(rst), .cam(cam),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(xf_valid), .out_ready(xf_ready), .out_data(xf_data)
  );

  sprp_qdiv u_qdiv (
    .clk(clk), .rst(rst),
    .in_valid(xf_valid), .in_ready(xf_ready), .in_data(xf_data),
    .out_valid(qd_valid), .out_ready(qd_ready), .out_data(qd_data)
  );

  sprp_scale u_scale (
    .clk(clk), .rst(rst),
    .in_valid(qd_valid), .in_ready(qd_ready), .in_data(qd_data),
    .out_valid(sc_valid), .out_ready(sc_ready), .out_data(sc_data)
  );

  sprp_rect u_rect (
    .clk(clk), .rst(rst),
    .in_valid(sc_valid), .in_ready(sc_ready), .in_data(sc_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

[rtl/sprp_checker.sv]
// Port-level checks for the sprite projection block and their bind.
`default_nettype none
module sprp_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire sprp_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_det_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |-> !out_data.visible && out_data.depth == 32'sd0 &&
      out_data.extent == 15'd0 && out_data.center_col == 16'sd0)
    else $error("zero determinant result not cleared");

  a_hidden: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res && !out_data.visible |->
      out_data.extent == 15'd0 && out_data.top_row == 16'sd0 && out_data.right_col == 16'sd0)
    else $error("hidden sprite carries a rectangle");

  a_visible: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.visible |-> out_data.valid_res && !out_data.depth[31] &&
      out_data.depth != 32'sd0 && !out_data.top_row[15] && !out_data.left_col[15])
    else $error("visible sprite with bad depth or rectangle");

endmodule

bind sprite_screen_projection sprp_checker u_sprp_checker (.*);
`default_nettype wire
